/* rtl/core/keyframe_vector_lerp_core_assert.svh */
`ifndef KEYFRAME_VECTOR_LERP_CORE_ASSERT_SVH
`define KEYFRAME_VECTOR_LERP_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KVL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kvl assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define KVL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kvl assertion failed");

`endif

/* rtl/core/kvl_pkg.sv */
package kvl_pkg;

  localparam int TIME_W  = 32;
  localparam int VAL_W   = 32;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] key_time;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
  } entry_t;

endpackage

/* rtl/core/kvl_ifs.sv */
interface kvl_in_if import kvl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [SLOT_W-1:0]        key_slot;
  logic [TIME_W-1:0]        key_time;
  logic signed [VAL_W-1:0]  key_x;
  logic signed [VAL_W-1:0]  key_y;
  logic signed [VAL_W-1:0]  key_z;
  logic [TIME_W-1:0]        query_time;

  modport source (output valid, func, key_slot, key_time, key_x, key_y, key_z, query_time,
                  input ready);
  modport sink (input valid, func, key_slot, key_time, key_x, key_y, key_z, query_time,
                output ready);
endinterface

interface kvl_out_if import kvl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  out_x;
  logic signed [VAL_W-1:0]  out_y;
  logic signed [VAL_W-1:0]  out_z;
  logic [IDX_W-1:0]         found_index;

  modport source (output valid, out_x, out_y, out_z, found_index, input ready);
  modport sink (input valid, out_x, out_y, out_z, found_index, output ready);
endinterface

/* rtl/core/kvl_ram.sv */
module kvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/keyframe_vector_lerp_core.sv */
// Keyframe track sampler for x/y/z vectors with linear interpolation. A write transaction
// (func 0) stores one key. In a query transaction (func 1) the start key is found by a
// linear scan at one key per cycle through the single read port of the key RAM, the
// factor comes from a restoring divider at one quotient bit per cycle, and one shared
// multiplier blends x, y and z in turn; the scan covers key_count keys, clamped to the
// range 1 to MAX_KEYS. Only one transaction is in flight; a finished result sits in an
// output register, so the next transaction is taken while it waits. Keys must be written
// before they are queried and kept in ascending time order; the user must write key_count
// only while the block is idle, and the block itself does not enforce it.
`include "keyframe_vector_lerp_core_assert.svh"

module keyframe_vector_lerp_core import kvl_pkg::*; #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  kvl_in_if.sink             item,
  kvl_out_if.source          result
);

  localparam int AW      = $clog2(MAX_KEYS);
  localparam int CW      = AW + 1;
  localparam int ENTRY_W = $bits(entry_t);
  localparam int PW      = VAL_W + 2 + FRAC_BITS;
  localparam int DCW     = $clog2(FRAC_BITS);

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SEARCH = 8'b0000_0010,
    S_LOAD   = 8'b0000_0100,
    S_PREP   = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_ADD    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   key_count;
  logic [CW-1:0]        n_eff;
  logic [CW-1:0]        n;
  logic [TIME_W-1:0]    q;
  logic [CW-1:0]        cnt;
  logic [AW-1:0]        chk;
  logic                 chk_vld;
  logic [AW-1:0]        idx;
  logic                 interp;
  entry_t               end_ent;
  entry_t               start_ent;
  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    den;
  logic [TIME_W:0]      rem_sh;
  logic                 rem_ge;
  logic [FRAC_BITS-1:0] factor;
  logic [DCW-1:0]       bitcnt;
  logic [1:0]           comp;
  logic [VAL_W-1:0]     s_sel;
  logic [VAL_W-1:0]     e_sel;
  logic signed [VAL_W:0] diff;
  logic signed [PW-1:0] prod;
  logic [VAL_W-1:0]     res_x;
  logic [VAL_W-1:0]     res_y;
  logic [VAL_W-1:0]     res_z;
  logic [VAL_W-1:0]     blend_val;

  logic                 out_vld;
  logic [VAL_W-1:0]     out_x_r;
  logic [VAL_W-1:0]     out_y_r;
  logic [VAL_W-1:0]     out_z_r;
  logic [IDX_W-1:0]     out_idx_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  entry_t               ram_wdata;
  entry_t               rd;
  logic                 in_acc;
  logic                 out_load;

  assign in_acc   = item.valid && item.ready;
  assign out_load = (state == S_DONE) && (!out_vld || result.ready);

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = out_vld;
  assign result.out_x       = out_x_r;
  assign result.out_y       = out_y_r;
  assign result.out_z       = out_z_r;
  assign result.found_index = out_idx_r;

  always_comb begin
    if (key_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      n_eff = CW'(MAX_KEYS);
    end else begin
      n_eff = CW'(key_count);
    end
  end

  // slots beyond the track are dropped
  assign ram_we             = in_acc && (item.func == FUNC_WRITE) &&
                              (32'(item.key_slot) < MAX_KEYS);
  assign ram_wdata.key_time = item.key_time;
  assign ram_wdata.x        = item.key_x;
  assign ram_wdata.y        = item.key_y;
  assign ram_wdata.z        = item.key_z;

  always_comb begin
    case (state)
      S_SEARCH: ram_raddr = cnt[AW-1:0];
      default:  ram_raddr = idx;
    endcase
  end

  kvl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(item.key_slot)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // restoring divide step
  assign rem_sh = {rem, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den});

  always_comb begin
    case (comp)
      COMP_X: begin
        s_sel = start_ent.x;
        e_sel = end_ent.x;
      end
      COMP_Y: begin
        s_sel = start_ent.y;
        e_sel = end_ent.y;
      end
      default: begin
        s_sel = start_ent.z;
        e_sel = end_ent.z;
      end
    endcase
  end

  assign diff      = $signed({e_sel[VAL_W-1], e_sel}) - $signed({s_sel[VAL_W-1], s_sel});
  // arithmetic shift of the product floors toward minus infinity
  assign blend_val = s_sel + prod[FRAC_BITS +: VAL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= COUNT_W'(1);
      chk_vld   <= 1'b0;
      out_vld   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_count <= cfg_wr_data;
      end

      if (out_load) begin
        out_vld <= 1'b1;
      end else if (result.ready) begin
        out_vld <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          chk_vld <= 1'b0;
          if (in_acc && item.func == FUNC_QUERY) begin
            q <= item.query_time;
            n <= n_eff;
            if (n_eff == CW'(1)) begin
              idx    <= '0;
              interp <= 1'b0;
              state  <= S_LOAD;
            end else begin
              cnt   <= CW'(1);
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (cnt < n) begin
            cnt <= cnt + CW'(1);
          end
          chk <= cnt[AW-1:0];
          if (chk_vld && q < rd.key_time) begin
            idx     <= chk - AW'(1);
            interp  <= 1'b1;
            end_ent <= rd;
            chk_vld <= 1'b0;
            state   <= S_LOAD;
          end else if (chk_vld && {1'b0, chk} == n - CW'(1)) begin
            // final key: returned as stored
            idx     <= chk;
            res_x   <= rd.x;
            res_y   <= rd.y;
            res_z   <= rd.z;
            chk_vld <= 1'b0;
            state   <= S_DONE;
          end else begin
            chk_vld <= (cnt < n);
          end
        end
        S_LOAD: begin
          state <= S_PREP;
        end
        S_PREP: begin
          start_ent <= rd;
          if (!interp) begin
            res_x <= rd.x;
            res_y <= rd.y;
            res_z <= rd.z;
            state <= S_DONE;
          end else begin
            rem    <= q - rd.key_time;
            den    <= end_ent.key_time - rd.key_time;
            factor <= '0;
            bitcnt <= '0;
            comp   <= COMP_X;
            if (end_ent.key_time > rd.key_time && q > rd.key_time) begin
              state <= S_DIV;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_DIV: begin
          rem    <= rem_ge ? TIME_W'(rem_sh - {1'b0, den}) : rem_sh[TIME_W-1:0];
          factor <= {factor[FRAC_BITS-2:0], rem_ge};
          bitcnt <= bitcnt + DCW'(1);
          if (bitcnt == DCW'(FRAC_BITS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= diff * $signed({1'b0, factor});
          state <= S_ADD;
        end
        S_ADD: begin
          case (comp)
            COMP_X:  res_x <= blend_val;
            COMP_Y:  res_y <= blend_val;
            default: res_z <= blend_val;
          endcase
          if (comp == COMP_Z) begin
            state <= S_DONE;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r   <= res_x;
      out_y_r   <= res_y;
      out_z_r   <= res_z;
      out_idx_r <= IDX_W'(idx);
    end
  end

  `KVL_ASSERT_NEXT(a_done_holds, (state == S_DONE) && out_vld && !result.ready, state == S_DONE)
  `KVL_ASSERT_NOW(a_chk_in_track, chk_vld, {1'b0, chk} < n)
  `KVL_ASSERT_NOW(a_div_has_next_key, state == S_DIV, ({1'b0, idx} + CW'(1)) < n)
  `KVL_ASSERT_NOW(a_div_rem_below_den, state == S_DIV, rem < den)

endmodule
